/* hdl/ped_pkg.sv */
package ped_pkg;

  localparam int unsigned MAX_VECTORS_DEF    = 1024;
  localparam int unsigned MAX_COMPONENTS_DEF = 64;
  localparam int unsigned COMPONENT_BITS     = 24;

  localparam int unsigned PULSES_W   = 11;
  localparam int unsigned DIMS_W     = 7;
  localparam int unsigned INDEX_W    = 11;
  localparam int unsigned DIST_W     = 28;
  localparam int unsigned POINTER_W  = 17;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [PULSES_W-1:0] PULSES_RESET = 11'd1024;
  localparam logic [DIMS_W-1:0]   DIMS_RESET   = 7'd64;
  localparam logic [DIST_W-1:0]   DIST_MAX     = 28'hFFFFFFF;

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } ped_op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_DROP  = 2'd2
  } ped_status_e;

  typedef enum logic [0:0] {
    CFG_NUM_PULSES = 1'b0,
    CFG_NUM_DIMS   = 1'b1
  } ped_cfg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_DRAIN,
    S_ROOT,
    S_EMIT
  } ped_state_e;

  typedef struct packed {
    ped_op_e                          opcode;
    logic signed [COMPONENT_BITS-1:0] component_value;
    logic [INDEX_W-1:0]               first_index;
    logic [INDEX_W-1:0]               second_index;
  } ped_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    ped_status_e       status;
  } ped_out_t;

  typedef struct packed {
    logic clear;
    logic issue;
  } ped_acc_ctrl_t;

endpackage

/* hdl/ped_store.sv */
module ped_store #(
  parameter int unsigned Depth = 65536,
  parameter int unsigned AddrW = 16
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [AddrW-1:0]                    waddr_i,
  input  logic [ped_pkg::COMPONENT_BITS-1:0]  wdata_i,
  input  logic                                re_i,
  input  logic [AddrW-1:0]                    raddr_a_i,
  input  logic [AddrW-1:0]                    raddr_b_i,
  output logic [ped_pkg::COMPONENT_BITS-1:0]  rdata_a_o,
  output logic [ped_pkg::COMPONENT_BITS-1:0]  rdata_b_o
);

  logic [ped_pkg::COMPONENT_BITS-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

/* hdl/ped_accum.sv */
module ped_accum #(
  parameter int unsigned SumW = 57
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ped_pkg::ped_acc_ctrl_t              ctrl_i,
  input  logic [ped_pkg::COMPONENT_BITS-1:0]  rdata_a_i,
  input  logic [ped_pkg::COMPONENT_BITS-1:0]  rdata_b_i,
  output logic                                busy_o,
  output logic [SumW-1:0]                     sum_o
);

  localparam int unsigned CompW = ped_pkg::COMPONENT_BITS;
  localparam int unsigned MagW  = CompW + 1;
  localparam int unsigned SqrW  = 2 * MagW;

  logic v1_q, v2_q, v3_q;
  logic signed [MagW-1:0] diff;
  logic [MagW-1:0] mag_d, mag_q;
  logic [SqrW-1:0] sqr_q;
  logic [SumW-1:0] acc_q;

  assign diff  = $signed({rdata_a_i[CompW-1], rdata_a_i})
               - $signed({rdata_b_i[CompW-1], rdata_b_i});
  assign mag_d = diff[MagW-1] ? MagW'(-diff) : MagW'(diff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= ctrl_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      mag_q <= mag_d;
    end
    if (v2_q) begin
      sqr_q <= SqrW'(mag_q) * SqrW'(mag_q);
    end
    if (ctrl_i.clear) begin
      acc_q <= '0;
    end else if (v3_q) begin
      acc_q <= acc_q + SumW'(sqr_q);
    end
  end

  assign busy_o = v1_q | v2_q | v3_q;
  assign sum_o  = acc_q;

endmodule

/* hdl/ped_sqrt.sv */
module ped_sqrt #(
  parameter int unsigned SumW  = 57,
  parameter int unsigned RootW = 29
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SumW-1:0]  radicand_i,
  output logic             done_o,
  output logic [RootW-1:0] root_o
);

  localparam int unsigned SqW  = 2 * RootW;
  localparam int unsigned CntW = $clog2(RootW + 1);

  logic             busy_q, done_q;
  logic [CntW-1:0]  cnt_q;
  logic [SqW-1:0]   rad_q;
  logic [RootW+1:0] rem_q, rem_sh, trial;
  logic [RootW-1:0] root_q;

  assign rem_sh = {rem_q[RootW-1:0], rad_q[SqW-1 -: 2]};
  assign trial  = {root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(RootW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= SqW'(radicand_i);
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[SqW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[RootW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

/* hdl/pairwise_euclidean_distance_store.sv */
// Channel | Direction | Handshake                  | Payload
// in      | input     | in_valid_i / in_ready_o    | in_data_i   (ped_in_t)
// out     | output    | out_valid_o / out_ready_i  | out_data_o  (ped_out_t)
// cfg     | input     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One item at a time. A load, a rejected query, an adjacent query or a query with
// zero components goes straight to the output stage. A full query makes one store
// read pair per component, drains the pipeline and starts the root, takes one root
// bit per cycle, then takes the root and hands it to the output. Reset clears the
// load pointer and output valid and sets num_pulses to 1024 and num_dims to 64;
// the store holds no reset. A stalled output holds its result; the next item is
// taken while it waits.
module pairwise_euclidean_distance_store #(
  parameter int unsigned MaxVectors    = ped_pkg::MAX_VECTORS_DEF,
  parameter int unsigned MaxComponents = ped_pkg::MAX_COMPONENTS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  ped_pkg::ped_in_t                   in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output ped_pkg::ped_out_t                  out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  ped_pkg::ped_cfg_e                  cfg_index_i,
  input  logic [ped_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned Depth = MaxVectors * MaxComponents;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned SumW  = 2 * (ped_pkg::COMPONENT_BITS + 1)
                                + $clog2(MaxComponents + 1);
  localparam int unsigned RootW = (SumW + 1) / 2;
  localparam int unsigned ProdW = ped_pkg::PULSES_W + ped_pkg::DIMS_W;
  localparam int unsigned CmpW  = RootW + ped_pkg::DIST_W;

  ped_pkg::ped_state_e state_q, state_d;

  logic [ped_pkg::PULSES_W-1:0]  num_pulses_q;
  logic [ped_pkg::DIMS_W-1:0]    num_dims_q;
  logic [ped_pkg::POINTER_W-1:0] ptr_q;
  logic [ped_pkg::PULSES_W-1:0]  n_eff;
  logic [ped_pkg::DIMS_W-1:0]    d_eff, cnt_q;
  logic [ProdW-1:0]              store_end, base_a, base_b;
  logic [AddrW-1:0]              addr_a_q, addr_b_q;

  logic in_acc, is_load, load_ok, q_bad, q_adj, go_fetch, fetch_last, emit;
  logic [ped_pkg::INDEX_W-1:0] idx_i, idx_j;

  ped_pkg::ped_acc_ctrl_t acc_ctrl;
  logic acc_busy, sqrt_start, sqrt_done, mem_re;
  logic [SumW-1:0]  acc_sum;
  logic [RootW-1:0] root;
  logic [ped_pkg::COMPONENT_BITS-1:0] rdata_a, rdata_b;

  ped_pkg::ped_out_t res_q, out_q;
  logic out_valid_q;
  logic [ped_pkg::DIST_W-1:0] dist_sat;

  assign n_eff = (32'(num_pulses_q) > MaxVectors) ? ped_pkg::PULSES_W'(MaxVectors)
                                                  : num_pulses_q;
  assign d_eff = (32'(num_dims_q) > MaxComponents) ? ped_pkg::DIMS_W'(MaxComponents)
                                                   : num_dims_q;
  assign store_end = ProdW'(n_eff) * ProdW'(d_eff);

  assign idx_i   = in_data_i.first_index;
  assign idx_j   = in_data_i.second_index;
  assign in_acc  = in_valid_i && in_ready_o;
  assign is_load = (in_data_i.opcode == ped_pkg::OP_LOAD);
  assign load_ok = (32'(ptr_q) < 32'(store_end)) && (32'(ptr_q) < Depth);
  assign q_bad   = (idx_i == '0) || (idx_j > n_eff) || (idx_i >= idx_j);
  assign q_adj   = (idx_j == idx_i + ped_pkg::INDEX_W'(1));
  assign go_fetch = in_acc && !is_load && !q_bad && !q_adj && (d_eff != '0);
  assign base_a  = ProdW'(idx_i) * ProdW'(d_eff);
  assign base_b  = ProdW'(idx_j - ped_pkg::INDEX_W'(1)) * ProdW'(d_eff);
  assign fetch_last = (cnt_q == d_eff - ped_pkg::DIMS_W'(1));

  assign dist_sat = ({{ped_pkg::DIST_W{1'b0}}, root} > CmpW'(ped_pkg::DIST_MAX))
                  ? ped_pkg::DIST_MAX : ped_pkg::DIST_W'(root);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ped_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = go_fetch ? ped_pkg::S_FETCH : ped_pkg::S_EMIT;
        end
      end
      ped_pkg::S_FETCH: begin
        if (fetch_last) begin
          state_d = ped_pkg::S_DRAIN;
        end
      end
      ped_pkg::S_DRAIN: begin
        if (!acc_busy) begin
          state_d = ped_pkg::S_ROOT;
        end
      end
      ped_pkg::S_ROOT: begin
        if (sqrt_done) begin
          state_d = ped_pkg::S_EMIT;
        end
      end
      ped_pkg::S_EMIT: begin
        if (emit) begin
          state_d = ped_pkg::S_IDLE;
        end
      end
      default: state_d = ped_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    mem_re         = 1'b0;
    acc_ctrl.clear = 1'b0;
    acc_ctrl.issue = 1'b0;
    sqrt_start     = 1'b0;
    emit           = 1'b0;
    case (state_q)
      ped_pkg::S_IDLE: begin
        in_ready_o     = 1'b1;
        acc_ctrl.clear = 1'b1;
      end
      ped_pkg::S_FETCH: begin
        mem_re         = 1'b1;
        acc_ctrl.issue = 1'b1;
      end
      ped_pkg::S_DRAIN: sqrt_start = !acc_busy;
      ped_pkg::S_EMIT:  emit = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ped_pkg::S_IDLE;
      num_pulses_q <= ped_pkg::PULSES_RESET;
      num_dims_q   <= ped_pkg::DIMS_RESET;
      ptr_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          ped_pkg::CFG_NUM_PULSES: num_pulses_q <= cfg_data_i;
          ped_pkg::CFG_NUM_DIMS:   num_dims_q   <= cfg_data_i[ped_pkg::DIMS_W-1:0];
          default: ;
        endcase
      end
      if (in_acc && is_load && load_ok) begin
        ptr_q <= ptr_q + ped_pkg::POINTER_W'(1);
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      addr_a_q       <= AddrW'(base_a);
      addr_b_q       <= AddrW'(base_b);
      cnt_q          <= '0;
      res_q.distance <= '0;
      if (is_load) begin
        res_q.status <= load_ok ? ped_pkg::STAT_OK : ped_pkg::STAT_DROP;
      end else begin
        res_q.status <= q_bad ? ped_pkg::STAT_RANGE : ped_pkg::STAT_OK;
      end
    end else if (state_q == ped_pkg::S_FETCH) begin
      addr_a_q <= addr_a_q + AddrW'(1);
      addr_b_q <= addr_b_q + AddrW'(1);
      cnt_q    <= cnt_q + ped_pkg::DIMS_W'(1);
    end else if (state_q == ped_pkg::S_ROOT && sqrt_done) begin
      res_q.distance <= dist_sat;
      res_q.status   <= ped_pkg::STAT_OK;
    end
    if (emit) begin
      out_q <= res_q;
    end
  end

  ped_store #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (in_acc && is_load && load_ok),
    .waddr_i   (AddrW'(ptr_q)),
    .wdata_i   (in_data_i.component_value),
    .re_i      (mem_re),
    .raddr_a_i (addr_a_q),
    .raddr_b_i (addr_b_q),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  ped_accum #(
    .SumW (SumW)
  ) u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (acc_ctrl),
    .rdata_a_i (rdata_a),
    .rdata_b_i (rdata_b),
    .busy_o    (acc_busy),
    .sum_o     (acc_sum)
  );

  ped_sqrt #(
    .SumW  (SumW),
    .RootW (RootW)
  ) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (acc_sum),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* hdl/ped_checker.sv */
module ped_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input ped_pkg::ped_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input ped_pkg::ped_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transfer dropped or changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ped_pkg::STAT_OK |-> out_data_o.distance == '0)
    else $error("nonzero distance on a flagged result");

  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second input transfer taken while an item is in flight");

  a_bad_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.opcode == ped_pkg::OP_QUERY
      && in_data_i.second_index <= in_data_i.first_index
    |=> ##1 out_valid_o)
    else $error("rejected query finished without its result");

endmodule

bind pairwise_euclidean_distance_store ped_checker u_ped_checker (.*);

/* bench/pairwise_euclidean_distance_store_tb.sv */
module pairwise_euclidean_distance_store_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomItems = 1426;

  class distance_tracker;
    logic signed [ped_pkg::COMPONENT_BITS-1:0]
      comp_mem [ped_pkg::MAX_VECTORS_DEF*ped_pkg::MAX_COMPONENTS_DEF];
    int unsigned                  write_ptr;
    logic [ped_pkg::PULSES_W-1:0] pulses_reg;
    logic [ped_pkg::DIMS_W-1:0]   dims_reg;
    ped_pkg::ped_out_t            pending_dist[$];
    int unsigned                  errors;
    int unsigned                  checked;

    function new();
      write_ptr  = 0;
      pulses_reg = ped_pkg::PULSES_RESET;
      dims_reg   = ped_pkg::DIMS_RESET;
      errors     = 0;
      checked    = 0;
    endfunction

    function int unsigned eff_pulses();
      return (32'(pulses_reg) > ped_pkg::MAX_VECTORS_DEF) ? ped_pkg::MAX_VECTORS_DEF
                                                          : 32'(pulses_reg);
    endfunction

    function int unsigned eff_dims();
      return (32'(dims_reg) > ped_pkg::MAX_COMPONENTS_DEF) ? ped_pkg::MAX_COMPONENTS_DEF
                                                           : 32'(dims_reg);
    endfunction

    function int unsigned pending();
      return pending_dist.size();
    endfunction

    function void set_reg(ped_pkg::ped_cfg_e idx, logic [ped_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        ped_pkg::CFG_NUM_PULSES: pulses_reg = data[ped_pkg::PULSES_W-1:0];
        ped_pkg::CFG_NUM_DIMS: dims_reg = data[ped_pkg::DIMS_W-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned floor_root(longint unsigned x);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= x) begin
          root = trial;
        end
      end
      return root;
    endfunction

    function void take_item(ped_pkg::ped_in_t it);
      ped_pkg::ped_out_t want;
      int unsigned       n;
      int unsigned       d;
      int unsigned       i;
      int unsigned       j;
      longint            a;
      longint            b;
      longint unsigned   mag;
      longint unsigned   acc;
      longint unsigned   root;
      n = eff_pulses();
      d = eff_dims();
      want.distance = '0;
      want.status   = ped_pkg::STAT_OK;
      if (it.opcode == ped_pkg::OP_LOAD) begin
        if (write_ptr < n * d) begin
          comp_mem[write_ptr] = it.component_value;
          write_ptr++;
        end else begin
          want.status = ped_pkg::STAT_DROP;
        end
      end else begin
        i = 32'(it.first_index);
        j = 32'(it.second_index);
        if (i < 1 || j > n || i >= j) begin
          want.status = ped_pkg::STAT_RANGE;
        end else if (j != i + 1) begin
          acc = 0;
          for (int unsigned c = 0; c < d; c++) begin
            a   = 64'(comp_mem[i * d + c]);
            b   = 64'(comp_mem[(j - 1) * d + c]);
            mag = (a >= b) ? a - b : b - a;
            acc += mag * mag;
          end
          root = floor_root(acc);
          want.distance = (root > 64'(ped_pkg::DIST_MAX)) ? ped_pkg::DIST_MAX
                                                          : root[ped_pkg::DIST_W-1:0];
        end
      end
      pending_dist = {pending_dist, want};
    endfunction

    function void match_result(ped_pkg::ped_out_t got);
      ped_pkg::ped_out_t want;
      checked++;
      if (pending_dist.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual distance %0d status %0d",
                 $time, got.distance, got.status);
        return;
      end
      want = pending_dist.pop_front();
      if (got.distance !== want.distance) begin
        errors++;
        $display("%0t: distance expected %0d actual %0d", $time, want.distance, got.distance);
      end
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      end
    endfunction

    function void report_leftover();
      ped_pkg::ped_out_t want;
      while (pending_dist.size() != 0) begin
        want = pending_dist.pop_front();
        errors++;
        $display("%0t: missing result, expected distance %0d status %0d, actual none",
                 $time, want.distance, want.status);
      end
    endfunction
  endclass

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_ready_o;
  ped_pkg::ped_in_t               in_data_i   = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  ped_pkg::ped_out_t              out_data_o;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  ped_pkg::ped_cfg_e              cfg_index_i = ped_pkg::CFG_NUM_PULSES;
  logic [ped_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;

  distance_tracker sb = new();
  bit              sender_calm;

  pairwise_euclidean_distance_store u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic signed [ped_pkg::COMPONENT_BITS-1:0] random_component();
    if ($urandom_range(0, 9) != 0) return ped_pkg::COMPONENT_BITS'($urandom);
    case ($urandom_range(0, 3))
      0: return {1'b0, {(ped_pkg::COMPONENT_BITS-1){1'b1}}};
      1: return {1'b1, {(ped_pkg::COMPONENT_BITS-1){1'b0}}};
      2: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic ped_pkg::ped_in_t load_item(
    logic signed [ped_pkg::COMPONENT_BITS-1:0] v);
    ped_pkg::ped_in_t it;
    it.opcode          = ped_pkg::OP_LOAD;
    it.component_value = v;
    it.first_index     = ped_pkg::INDEX_W'($urandom);
    it.second_index    = ped_pkg::INDEX_W'($urandom);
    return it;
  endfunction

  function automatic ped_pkg::ped_in_t query_item(int unsigned i, int unsigned j);
    ped_pkg::ped_in_t it;
    it.opcode          = ped_pkg::OP_QUERY;
    it.component_value = ped_pkg::COMPONENT_BITS'($urandom);
    it.first_index     = i[ped_pkg::INDEX_W-1:0];
    it.second_index    = j[ped_pkg::INDEX_W-1:0];
    return it;
  endfunction

  function automatic ped_pkg::ped_in_t valid_query();
    int unsigned n;
    int unsigned d;
    int unsigned top;
    int unsigned i;
    int unsigned j;
    n   = sb.eff_pulses();
    d   = sb.eff_dims();
    top = (d == 0) ? n : sb.write_ptr / d;
    if (top > n) top = n;
    if (top >= 2) begin
      j = $urandom_range(2, top);
      i = $urandom_range(1, j - 1);
    end else if (n >= 2) begin
      i = $urandom_range(1, n - 1);
      j = i + 1;
    end else begin
      i = $urandom_range(0, 2047);
      j = $urandom_range(0, 2047);
    end
    return query_item(i, j);
  endfunction

  function automatic ped_pkg::ped_in_t noise_query();
    int unsigned n;
    int unsigned d;
    int unsigned i;
    int unsigned j;
    n = sb.eff_pulses();
    d = sb.eff_dims();
    i = $urandom_range(0, 2047);
    j = $urandom_range(0, 2047);
    case ($urandom_range(0, 3))
      0: i = 0;
      1: i = j;
      default: ;
    endcase
    // keep away from never-written store entries
    if (i >= 1 && j <= n && i < j && j != i + 1 && d > 0 && j * d > sb.write_ptr) begin
      i = j;
    end
    return query_item(i, j);
  endfunction

  task automatic push_item(ped_pkg::ped_in_t it, int unsigned gap);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.take_item(it);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_batch(ped_pkg::ped_in_t batch[$]);
    for (int k = 0; k < batch.size(); k++) begin
      push_item(batch[k], (k == batch.size() - 1) ? 1 + gap_len() : gap_len());
    end
  endtask

  task automatic write_reg(ped_pkg::ped_cfg_e idx, logic [ped_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic settle_and_configure(int unsigned pulses, int unsigned dims);
    int unsigned junk;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    junk = $urandom_range(0, 15);
    write_reg(ped_pkg::CFG_NUM_PULSES, pulses[ped_pkg::CFG_DATA_W-1:0]);
    write_reg(ped_pkg::CFG_NUM_DIMS,
              ped_pkg::CFG_DATA_W'((junk << ped_pkg::DIMS_W) | dims));
  endtask

  task automatic random_settings();
    int unsigned dims;
    int unsigned dd;
    int unsigned pulses;
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) dims = $urandom_range(1, 6);
    else if (r < 8) dims = $urandom_range(7, 64);
    else if (r < 9) dims = $urandom_range(65, 127);
    else dims = 0;
    dd = (dims > ped_pkg::MAX_COMPONENTS_DEF) ? ped_pkg::MAX_COMPONENTS_DEF : dims;
    r = $urandom_range(0, 9);
    if (r < 4) pulses = ((dd == 0) ? 0 : sb.write_ptr / dd) + $urandom_range(2, 8);
    else if (r < 7) pulses = $urandom_range(2, 40);
    else if (r < 9) pulses = $urandom_range(1025, 2047);
    else pulses = $urandom_range(0, 1);
    if (pulses > 2047) pulses = 2047;
    settle_and_configure(pulses, dims);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.match_result(out_data_o);
    end
  end

  initial begin : sink
    int unsigned stall_left;
    int unsigned calm_left;
    int unsigned holds;
    stall_left = 0;
    calm_left  = 0;
    holds      = 0;
    forever begin
      @(posedge clk_i);
      if ((holds == 0 && sb.checked >= 300) || (holds == 1 && sb.checked >= 1000)) begin
        holds++;
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      if (calm_left > 0) begin
        calm_left--;
        out_ready_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        case ($urandom_range(0, 9))
          0: calm_left = $urandom_range(20, 150);
          1, 2, 3: stall_left = gap_len();
          default: ;
        endcase
      end
    end
  end

  initial begin : stimulus
    ped_pkg::ped_in_t batch[$];
    ped_pkg::ped_in_t it;
    int unsigned      sent;
    int unsigned      count;
    int unsigned      load_pct;
    int unsigned      r;
    int unsigned      gap;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    settle_and_configure(3, 2);
    batch = {};
    batch = {batch, load_item(24'sd0)};
    batch = {batch, load_item(24'sd0)};
    batch = {batch, load_item(24'sh7FFFFF)};
    batch = {batch, load_item(24'sh800000)};
    batch = {batch, load_item(24'sh800000)};
    batch = {batch, load_item(24'sh7FFFFF)};
    batch = {batch, load_item(24'sd12345)};
    batch = {batch, query_item(1, 3)};
    batch = {batch, query_item(1, 2)};
    batch = {batch, query_item(2, 3)};
    batch = {batch, query_item(0, 2)};
    batch = {batch, query_item(1, 4)};
    batch = {batch, query_item(2, 2)};
    batch = {batch, query_item(3, 1)};
    batch = {batch, query_item(2047, 2047)};
    send_batch(batch);

    settle_and_configure(2047, 127);
    batch = {};
    batch = {batch, load_item(-24'sd1)};
    batch = {batch, query_item(1023, 1024)};
    batch = {batch, query_item(1, 1025)};
    batch = {batch, query_item(1024, 2047)};
    send_batch(batch);

    settle_and_configure(1024, 0);
    batch = {};
    batch = {batch, load_item(24'sd5)};
    batch = {batch, query_item(1, 1024)};
    send_batch(batch);

    settle_and_configure(1, 1);
    batch = {};
    batch = {batch, load_item(24'sd7)};
    batch = {batch, query_item(1, 2)};
    send_batch(batch);

    settle_and_configure(0, 64);
    batch = {};
    batch = {batch, query_item(0, 0)};
    send_batch(batch);

    sent = 0;
    while (sent < RandomItems) begin
      random_settings();
      sender_calm = ($urandom_range(0, 3) == 0);
      count       = $urandom_range(40, 120);
      if (count > RandomItems - sent) count = RandomItems - sent;
      load_pct    = $urandom_range(25, 70);
      for (int unsigned k = 0; k < count; k++) begin
        r = $urandom_range(0, 99);
        if (r < load_pct) it = load_item(random_component());
        else if (r < load_pct + (100 - load_pct) * 3 / 4) it = valid_query();
        else it = noise_query();
        if (k == count - 1) gap = 1 + gap_len();
        else gap = sender_calm ? 0 : gap_len();
        push_item(it, gap);
      end
      sent += count;
    end

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    sb.report_leftover();
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* pairwise_euclidean_distance_store.f */
hdl/ped_pkg.sv
hdl/ped_store.sv
hdl/ped_accum.sv
hdl/ped_sqrt.sv
hdl/pairwise_euclidean_distance_store.sv
hdl/ped_checker.sv
bench/pairwise_euclidean_distance_store_tb.sv
